// File: design/vole_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package vole_pkg;

  localparam int MEM_DEPTH = 256;
  localparam int NUM_REGS  = 16;
  localparam int MEM_AW    = $clog2(MEM_DEPTH);
  localparam int REG_AW    = $clog2(NUM_REGS);
  localparam int UPC_W     = 5;
  localparam int FSUM_W    = 13;   // signed sum of two float magnitudes in 2^-8 units

  // item kinds
  localparam logic [2:0] KIND_WRITE    = 3'd0;
  localparam logic [2:0] KIND_EXEC     = 3'd1;
  localparam logic [2:0] KIND_RESTART  = 3'd2;
  localparam logic [2:0] KIND_READ_MEM = 3'd3;
  localparam logic [2:0] KIND_READ_REG = 3'd4;

  // opcodes
  localparam logic [3:0] OP_LOAD  = 4'h1;
  localparam logic [3:0] OP_LOADI = 4'h2;
  localparam logic [3:0] OP_STORE = 4'h3;
  localparam logic [3:0] OP_MOVE  = 4'h4;
  localparam logic [3:0] OP_ADD   = 4'h5;
  localparam logic [3:0] OP_FADD  = 4'h6;
  localparam logic [3:0] OP_JEQ   = 4'hB;
  localparam logic [3:0] OP_HALT  = 4'hC;

  typedef enum logic [1:0] {ST_OK, ST_HALT_OP, ST_OFF, ST_HALTED} status_t;
  typedef enum logic [1:0] {AS_PC, AS_PC1, AS_XY, AS_IN} addr_sel_t;
  typedef enum logic [2:0] {RS_R, RS_S, RS_T, RS_ZERO, RS_IN} rsel_t;
  typedef enum logic [2:0] {WS_MEM, WS_XY, WS_REG, WS_ADD, WS_FNORM} wsrc_t;
  typedef enum logic [1:0] {PC_HOLD, PC_INC2, PC_XY, PC_START} pc_op_t;
  typedef enum logic [1:0] {HO_HOLD, HO_SET, HO_CLR} halt_op_t;
  typedef enum logic [1:0] {RD_NONE, RD_MEM, RD_REG} rd_src_t;
  typedef enum logic [2:0] {J_NEXT, J_GOTO, J_CHECK, J_EQ, J_DISPATCH, J_END} jmp_t;

  // one microcode word
  typedef struct packed {
    addr_sel_t         addr_sel;
    logic              mem_we;
    logic              wdata_reg;   // store register operand instead of item data
    logic              ir_hi_ld;
    logic              ir_lo_ld;
    rsel_t             rsel;
    logic              a_ld;
    logic              fsum_ld;
    logic              reg_we;
    logic              wdst_t;      // write register T instead of R
    wsrc_t             wsrc;
    pc_op_t            pc_op;
    halt_op_t          halt_op;
    rd_src_t           rd_src;
    status_t           status;
    jmp_t              jmp;
    logic [UPC_W-1:0]  target;
  } ctl_t;

  // datapath conditions seen by the sequencer
  typedef struct packed {
    logic       halted;
    logic       fetch_off;
    logic       eq;
    logic [3:0] op;
  } cond_t;

  // microprogram addresses
  localparam logic [UPC_W-1:0] U_WR     = UPC_W'(0);
  localparam logic [UPC_W-1:0] U_EX0    = UPC_W'(1);
  localparam logic [UPC_W-1:0] U_EX1    = UPC_W'(2);
  localparam logic [UPC_W-1:0] U_EX2    = UPC_W'(3);
  localparam logic [UPC_W-1:0] U_HALTED = UPC_W'(4);
  localparam logic [UPC_W-1:0] U_OFF    = UPC_W'(5);   // must follow U_HALTED
  localparam logic [UPC_W-1:0] U_HLT    = UPC_W'(6);
  localparam logic [UPC_W-1:0] U_LD0    = UPC_W'(7);
  localparam logic [UPC_W-1:0] U_LD1    = UPC_W'(8);
  localparam logic [UPC_W-1:0] U_FIN    = UPC_W'(9);
  localparam logic [UPC_W-1:0] U_LDI    = UPC_W'(10);
  localparam logic [UPC_W-1:0] U_ST     = UPC_W'(11);
  localparam logic [UPC_W-1:0] U_MV     = UPC_W'(12);
  localparam logic [UPC_W-1:0] U_ADD0   = UPC_W'(13);
  localparam logic [UPC_W-1:0] U_ADD1   = UPC_W'(14);
  localparam logic [UPC_W-1:0] U_FA0    = UPC_W'(15);
  localparam logic [UPC_W-1:0] U_FA1    = UPC_W'(16);
  localparam logic [UPC_W-1:0] U_FA2    = UPC_W'(17);
  localparam logic [UPC_W-1:0] U_JB0    = UPC_W'(18);
  localparam logic [UPC_W-1:0] U_JB1    = UPC_W'(19);
  localparam logic [UPC_W-1:0] U_JBN    = UPC_W'(20);
  localparam logic [UPC_W-1:0] U_JMP    = UPC_W'(21);
  localparam logic [UPC_W-1:0] U_RST    = UPC_W'(22);
  localparam logic [UPC_W-1:0] U_RM0    = UPC_W'(23);
  localparam logic [UPC_W-1:0] U_RM1    = UPC_W'(24);
  localparam logic [UPC_W-1:0] U_RR     = UPC_W'(25);
  localparam logic [UPC_W-1:0] U_NOP    = UPC_W'(26);

  // microcode ROM
  function automatic ctl_t ucode(input logic [UPC_W-1:0] a);
    ctl_t c;
    c = '0;
    c.jmp = J_END;
    unique case (a)
      U_WR:     begin c.addr_sel = AS_IN; c.mem_we = 1'b1; end
      U_EX0:    begin c.addr_sel = AS_PC; c.jmp = J_CHECK; c.target = U_HALTED; end
      U_EX1:    begin c.addr_sel = AS_PC1; c.ir_hi_ld = 1'b1; c.jmp = J_NEXT; end
      U_EX2:    begin c.ir_lo_ld = 1'b1; c.jmp = J_DISPATCH; end
      U_HALTED: begin c.status = ST_HALTED; end
      U_OFF:    begin c.halt_op = HO_SET; c.status = ST_OFF; end
      U_HLT:    begin c.halt_op = HO_SET; c.status = ST_HALT_OP; end
      U_LD0:    begin c.addr_sel = AS_XY; c.jmp = J_NEXT; end
      U_LD1:    begin
        c.reg_we = 1'b1; c.wsrc = WS_MEM; c.jmp = J_GOTO; c.target = U_FIN;
      end
      U_FIN:    begin c.pc_op = PC_INC2; end
      U_LDI:    begin
        c.reg_we = 1'b1; c.wsrc = WS_XY; c.jmp = J_GOTO; c.target = U_FIN;
      end
      U_ST:     begin
        c.rsel = RS_R; c.addr_sel = AS_XY; c.mem_we = 1'b1; c.wdata_reg = 1'b1;
        c.jmp = J_GOTO; c.target = U_FIN;
      end
      U_MV:     begin
        c.rsel = RS_S; c.reg_we = 1'b1; c.wsrc = WS_REG; c.wdst_t = 1'b1;
        c.jmp = J_GOTO; c.target = U_FIN;
      end
      U_ADD0:   begin c.rsel = RS_S; c.a_ld = 1'b1; c.jmp = J_NEXT; end
      U_ADD1:   begin
        c.rsel = RS_T; c.reg_we = 1'b1; c.wsrc = WS_ADD; c.jmp = J_GOTO; c.target = U_FIN;
      end
      U_FA0:    begin c.rsel = RS_S; c.a_ld = 1'b1; c.jmp = J_NEXT; end
      U_FA1:    begin c.rsel = RS_T; c.fsum_ld = 1'b1; c.jmp = J_NEXT; end
      U_FA2:    begin
        c.reg_we = 1'b1; c.wsrc = WS_FNORM; c.jmp = J_GOTO; c.target = U_FIN;
      end
      U_JB0:    begin c.rsel = RS_ZERO; c.a_ld = 1'b1; c.jmp = J_NEXT; end
      U_JB1:    begin c.rsel = RS_R; c.jmp = J_EQ; c.target = U_JMP; end
      U_JBN:    begin c.pc_op = PC_INC2; end
      U_JMP:    begin c.pc_op = PC_XY; end
      U_RST:    begin c.pc_op = PC_START; c.halt_op = HO_CLR; end
      U_RM0:    begin c.addr_sel = AS_IN; c.jmp = J_NEXT; end
      U_RM1:    begin c.rd_src = RD_MEM; end
      U_RR:     begin c.rsel = RS_IN; c.rd_src = RD_REG; end
      default:  ;
    endcase
    return c;
  endfunction

  function automatic logic [UPC_W-1:0] kind_entry(input logic [2:0] kind);
    logic [UPC_W-1:0] u;
    unique case (kind)
      KIND_WRITE:    u = U_WR;
      KIND_EXEC:     u = U_EX0;
      KIND_RESTART:  u = U_RST;
      KIND_READ_MEM: u = U_RM0;
      KIND_READ_REG: u = U_RR;
      default:       u = U_NOP;
    endcase
    return u;
  endfunction

  function automatic logic [UPC_W-1:0] op_entry(input logic [3:0] op);
    logic [UPC_W-1:0] u;
    unique case (op)
      OP_LOAD:  u = U_LD0;
      OP_LOADI: u = U_LDI;
      OP_STORE: u = U_ST;
      OP_MOVE:  u = U_MV;
      OP_ADD:   u = U_ADD0;
      OP_FADD:  u = U_FA0;
      OP_JEQ:   u = U_JB0;
      OP_HALT:  u = U_HLT;
      default:  u = U_FIN;
    endcase
    return u;
  endfunction

  // float byte to signed value in 2^-8 units
  function automatic logic signed [FSUM_W-1:0] fvalue(input logic [7:0] f);
    logic [FSUM_W-1:0] mag;
    mag = FSUM_W'(f[3:0]) << f[6:4];
    return f[7] ? -$signed(mag) : $signed(mag);
  endfunction

  // normalize, truncate, saturate
  function automatic logic [7:0] fnorm(input logic signed [FSUM_W-1:0] s);
    logic [FSUM_W-1:0] mag;
    logic [FSUM_W-1:0] m;
    logic [2:0]        e;
    logic [3:0]        m4;
    mag = s[FSUM_W-1] ? $unsigned(-s) : $unsigned(s);
    e = 3'd0;
    // shifted magnitude is monotone, so exponent = number of shifts still above 15
    for (int i = 0; i < 7; i++) begin
      if ((mag >> i) > FSUM_W'(15)) e = e + 3'd1;
    end
    m  = mag >> e;
    m4 = (m > FSUM_W'(15)) ? 4'hF : m[3:0];
    if (mag == '0) return 8'h00;
    return {s[FSUM_W-1], e, m4};
  endfunction

endpackage

`default_nettype wire

// File: design/vole_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module vole_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

// File: design/vole_useq.sv
`timescale 1ns / 1ps
`default_nettype none

module vole_useq import vole_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       launch,
  input  wire logic [2:0] kind,
  input  wire cond_t      cond,
  output      ctl_t       ctl,
  output      logic       running,
  output      logic       done
);

  logic [UPC_W-1:0] upc_r, upc_nxt;
  logic             run_r, run_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= '0;
      run_r <= 1'b0;
    end else begin
      upc_r <= upc_nxt;
      run_r <= run_nxt;
    end
  end

  always_comb begin
    ctl     = run_r ? ucode(upc_r) : '0;
    running = run_r;
    done    = run_r && (ctl.jmp == J_END);
    upc_nxt = upc_r;
    run_nxt = run_r;
    if (launch) begin
      upc_nxt = kind_entry(kind);
      run_nxt = 1'b1;
    end else if (run_r) begin
      unique case (ctl.jmp)
        J_NEXT:     upc_nxt = upc_r + UPC_W'(1);
        J_GOTO:     upc_nxt = ctl.target;
        J_CHECK: begin
          if (cond.halted)         upc_nxt = ctl.target;
          else if (cond.fetch_off) upc_nxt = ctl.target + UPC_W'(1);
          else                     upc_nxt = upc_r + UPC_W'(1);
        end
        J_EQ:       upc_nxt = cond.eq ? ctl.target : upc_r + UPC_W'(1);
        J_DISPATCH: upc_nxt = op_entry(cond.op);
        default:    run_nxt = 1'b0;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: design/vole_cpu_step.sv
`timescale 1ns / 1ps
`default_nettype none

// Small 8-bit textbook CPU, one command item at a time.
// Input: drive in_kind/in_address/in_data with start; the item is taken on a
// clock edge where start is high and busy is low. Kinds: write memory byte,
// execute one instruction, restart at the start address, read memory byte,
// read register.
// Output: one result per item, shown for exactly one cycle with out_valid.
// out_pc, out_halted and out_instruction give machine state after the item.
// There is no back-pressure on results; the next item may be issued in the
// cycle that out_valid is high.
// Timing: a microcoded sequencer runs each item over a single-port byte RAM
// (one access per cycle, registered read). Execute fetches both instruction
// bytes, unless halted or at the end of memory, then runs the instruction;
// float add is the longest execute case.
// Configuration: cfg_valid writes cfg_data, the start address (cfg_ready is
// always high); user must do so only while no item is in flight, unenforced.
// Reset: synchronous, active low. Afterwards the block sweeps all MEM_DEPTH
// (256) bytes of memory to zero, one byte per cycle, with busy high.
module vole_cpu_step import vole_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // command channel
  input  wire logic        start,
  output      logic        busy,
  input  wire logic [2:0]  in_kind,
  input  wire logic [7:0]  in_address,
  input  wire logic [7:0]  in_data,
  // result channel
  output      logic        out_valid,
  output      logic [7:0]  out_pc,
  output      logic        out_halted,
  output      logic [15:0] out_instruction,
  output      logic [7:0]  out_read_data,
  output      logic [1:0]  out_status,
  // start address register
  input  wire logic        cfg_valid,
  output      logic        cfg_ready,
  input  wire logic [7:0]  cfg_data
);

  // sequencer
  ctl_t  ctl;
  cond_t cond;
  logic  running, done, accept;

  // clear sweep
  logic              clr_r, clr_nxt;
  logic [MEM_AW-1:0] clr_cnt_r, clr_cnt_nxt;

  // machine state
  logic [7:0]  pc_r, pc_nxt;
  logic        halt_r, halt_nxt;
  logic [15:0] ir_r, ir_nxt;
  logic [7:0]  start_r, start_nxt;
  logic [7:0]  rf_r [NUM_REGS];

  // item and scratch
  logic [7:0]               in_addr_r, in_addr_nxt;
  logic [7:0]               in_data_r, in_data_nxt;
  logic [7:0]               a_r, a_nxt;
  logic signed [FSUM_W-1:0] fsum_r, fsum_nxt;
  logic [7:0]               rd_r, rd_nxt;
  status_t                  status_r, status_nxt;
  logic                     valid_r, valid_nxt;
  logic                     mem_ok_r;

  // datapath nets
  logic [7:0]        mem_addr;
  logic              mem_in_range;
  logic [MEM_AW-1:0] ram_addr;
  logic              ram_we;
  logic [7:0]        ram_wdata, ram_q, mem_rd;
  logic [REG_AW-1:0] ridx, widx;
  logic [7:0]        reg_rdata, reg_wdata;
  logic              over;

  assign busy      = clr_r | running;
  assign accept    = start & ~busy;
  assign cfg_ready = 1'b1;

  assign cond.halted    = halt_r;
  assign cond.fetch_off = ({1'b0, pc_r} + 9'd1) >= 9'(MEM_DEPTH);
  assign cond.eq        = (reg_rdata == a_r);
  assign cond.op        = ir_r[15:12];

  vole_useq u_useq (
    .clk     (clk),
    .rst_n   (rst_n),
    .launch  (accept),
    .kind    (in_kind),
    .cond    (cond),
    .ctl     (ctl),
    .running (running),
    .done    (done)
  );

  // memory address and write port; the clear sweep owns the RAM after reset
  always_comb begin
    unique case (ctl.addr_sel)
      AS_PC:   mem_addr = pc_r;
      AS_PC1:  mem_addr = pc_r + 8'd1;
      AS_XY:   mem_addr = ir_r[7:0];
      AS_IN:   mem_addr = in_addr_r;
      default: mem_addr = pc_r;
    endcase
  end

  assign mem_in_range = {1'b0, mem_addr} < 9'(MEM_DEPTH);
  assign ram_addr  = clr_r ? clr_cnt_r : mem_addr[MEM_AW-1:0];
  assign ram_we    = clr_r | (ctl.mem_we & mem_in_range);
  assign ram_wdata = clr_r ? 8'h00 : (ctl.wdata_reg ? reg_rdata : in_data_r);
  // out-of-range reads give zero
  assign mem_rd    = mem_ok_r ? ram_q : 8'h00;

  vole_ram #(.WIDTH(8), .DEPTH(MEM_DEPTH)) u_mem (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_q)
  );

  // register file: one read port, one write port
  always_comb begin
    unique case (ctl.rsel)
      RS_R:    ridx = ir_r[11:8];
      RS_S:    ridx = ir_r[7:4];
      RS_T:    ridx = ir_r[3:0];
      RS_ZERO: ridx = '0;
      RS_IN:   ridx = in_addr_r[REG_AW-1:0];
      default: ridx = '0;
    endcase
  end

  assign reg_rdata = rf_r[ridx];
  assign widx      = ctl.wdst_t ? ir_r[3:0] : ir_r[11:8];

  always_comb begin
    unique case (ctl.wsrc)
      WS_MEM:   reg_wdata = mem_rd;
      WS_XY:    reg_wdata = ir_r[7:0];
      WS_REG:   reg_wdata = reg_rdata;
      WS_ADD:   reg_wdata = a_r + reg_rdata;   // wraps mod 256
      WS_FNORM: reg_wdata = fnorm(fsum_r);
      default:  reg_wdata = reg_rdata;
    endcase
  end

  // pc+2 past the end of memory halts after a non-jumping instruction
  assign over = ({1'b0, pc_r} + 9'd2) >= 9'(MEM_DEPTH);

  always_comb begin
    clr_nxt     = clr_r;
    clr_cnt_nxt = clr_cnt_r;
    pc_nxt      = pc_r;
    halt_nxt    = halt_r;
    ir_nxt      = ir_r;
    start_nxt   = start_r;
    in_addr_nxt = in_addr_r;
    in_data_nxt = in_data_r;
    a_nxt       = a_r;
    fsum_nxt    = fsum_r;
    rd_nxt      = rd_r;
    status_nxt  = status_r;
    valid_nxt   = done;

    if (clr_r) begin
      clr_cnt_nxt = clr_cnt_r + MEM_AW'(1);
      if (clr_cnt_r == MEM_AW'(MEM_DEPTH - 1)) clr_nxt = 1'b0;
    end

    if (cfg_valid && cfg_ready) start_nxt = cfg_data;

    if (accept) begin
      in_addr_nxt = in_address;
      in_data_nxt = in_data;
      rd_nxt      = 8'h00;
    end

    if (ctl.ir_hi_ld) ir_nxt[15:8] = mem_rd;
    if (ctl.ir_lo_ld) ir_nxt[7:0]  = mem_rd;
    if (ctl.a_ld)     a_nxt        = reg_rdata;
    if (ctl.fsum_ld)  fsum_nxt     = fvalue(a_r) + fvalue(reg_rdata);

    case (ctl.rd_src)
      RD_MEM:  rd_nxt = mem_rd;
      RD_REG:  rd_nxt = reg_rdata;
      default: ;
    endcase

    case (ctl.pc_op)
      PC_INC2:  pc_nxt = pc_r + 8'd2;
      PC_XY:    pc_nxt = ir_r[7:0];
      PC_START: pc_nxt = start_r;
      default:  ;
    endcase

    case (ctl.halt_op)
      HO_SET:  halt_nxt = 1'b1;
      HO_CLR:  halt_nxt = 1'b0;
      default: ;
    endcase

    if (done) begin
      status_nxt = ctl.status;
      if (ctl.pc_op == PC_INC2 && over) begin
        halt_nxt   = 1'b1;
        status_nxt = ST_OFF;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r     <= 1'b1;
      clr_cnt_r <= '0;
      pc_r      <= '0;
      halt_r    <= 1'b0;
      ir_r      <= '0;
      start_r   <= '0;
      rd_r      <= '0;
      status_r  <= ST_OK;
      valid_r   <= 1'b0;
      for (int i = 0; i < NUM_REGS; i++) rf_r[i] <= '0;
    end else begin
      clr_r     <= clr_nxt;
      clr_cnt_r <= clr_cnt_nxt;
      pc_r      <= pc_nxt;
      halt_r    <= halt_nxt;
      ir_r      <= ir_nxt;
      start_r   <= start_nxt;
      rd_r      <= rd_nxt;
      status_r  <= status_nxt;
      valid_r   <= valid_nxt;
      if (ctl.reg_we) rf_r[widx] <= reg_wdata;
    end
  end

  // scratch, no reset needed
  always_ff @(posedge clk) begin
    in_addr_r <= in_addr_nxt;
    in_data_r <= in_data_nxt;
    a_r       <= a_nxt;
    fsum_r    <= fsum_nxt;
    mem_ok_r  <= mem_in_range;
  end

  assign out_valid       = valid_r;
  assign out_pc          = pc_r;
  assign out_halted      = halt_r;
  assign out_instruction = ir_r;
  assign out_read_data   = rd_r;
  assign out_status      = status_r;

endmodule

`default_nettype wire

// File: design/vole_chk.sv
`timescale 1ns / 1ps
`default_nettype none

module vole_chk import vole_pkg::*; (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        start,
  input wire logic        busy,
  input wire logic [2:0]  in_kind,
  input wire logic        out_valid,
  input wire logic        out_halted,
  input wire logic [1:0]  out_status
);

  // an item holds the block for at least its first step
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy low right after an accepted item");

  // an item is accepted only once the previous one is done, so strobes never touch
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  // halting statuses always show the halt flag
  a_halt_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == ST_HALT_OP || out_status == ST_OFF ||
                   out_status == ST_HALTED)) |-> out_halted)
    else $error("halting status without halt flag");

  // a restart item answers running, with status ok
  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_kind == KIND_RESTART) |->
      ##2 (out_valid && !out_halted && out_status == ST_OK))
    else $error("restart result wrong");

endmodule

bind vole_cpu_step vole_chk u_vole_chk (.*);

`default_nettype wire
